@@ hdl/nearest_neighbor_table_lookup_assert.svh @@
// Assertion macros for the block's top module.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_TABLE_LOOKUP_ASSERT_SVH
`define NEAREST_NEIGHBOR_TABLE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NNL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NNL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nnl_pkg.sv @@
package nnl_pkg;

    // Request command codes.
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FOUND  = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_PUT
    } fsm_state_t;

    localparam int KEY_W   = 16;
    localparam int POWER_W = 32;
    localparam int SQ_W    = 2 * KEY_W;
    localparam int DIST_W  = SQ_W + 1;

    typedef struct packed {
        cmd_t               cmd;
        logic [KEY_W-1:0]   key_nop;
        logic [KEY_W-1:0]   key_vector;
        logic [POWER_W-1:0] entry_power;
    } req_item_t;

    typedef struct packed {
        logic [POWER_W-1:0] power_out;
        status_t            status;
    } res_item_t;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key_vector;
        logic [KEY_W-1:0]   key_nop;
        logic [POWER_W-1:0] power;
    } entry_t;

    // Control tag that travels down the scan pipeline with each entry.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

endpackage

@@ hdl/nearest_neighbor_table_lookup.sv @@
// Nearest-neighbor table lookup over two-dimensional 16-bit keys.
// Requests arrive on req_item with req_valid/req_stall; results leave on
// res_item with res_valid/res_stall. A request is taken at a rising edge with
// valid high and stall low, and each request gives exactly one result.
// A load request appends an entry (status loaded) or, with the table full,
// is dropped (status full). A query scans the stored entries in load order and
// returns the power of the entry with the smallest squared distance; the first
// loaded entry wins a tie. A query on an empty table returns status empty.
// A load or an empty query stages its result, which then moves to the output
// register. A query reads one stored entry per cycle from the table memory's
// read port; the read register, the difference and square registers of the
// squaring cells and the minimum cell then drain. The next request is taken
// once the result is placed in the output register, so a result may wait
// under res_stall while the next request runs.
// A result held under res_stall stays unchanged; a new result waits for it.
// Reset empties the table (the entry count goes to zero) and clears the
// output valid; the table memory itself is not cleared.
`include "nearest_neighbor_table_lookup_assert.svh"

module nearest_neighbor_table_lookup #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  nnl_pkg::req_item_t req_item,
    output logic               res_valid,
    input  logic               res_stall,
    output nnl_pkg::res_item_t res_item
);
    import nnl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsm_state_t         state_reg;
    fsm_state_t         state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      scan_reg;
    logic [CW-1:0]      scan_next;
    logic [CW-1:0]      scan_inc;
    logic [KEY_W-1:0]   qx_reg;
    logic [KEY_W-1:0]   qy_reg;
    res_item_t          res_reg;
    res_item_t          res_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    res_item_t          res_item_reg;
    res_item_t          res_item_next;
    logic               accept;
    logic               wr_en;
    logic               rd_en;
    entry_t             wr_data;
    entry_t             rd_data;
    scan_tag_t          issue_tag;
    scan_tag_t          tag0_reg;
    scan_tag_t          tag1_reg;
    scan_tag_t          tag2_reg;
    logic [POWER_W-1:0] power1_reg;
    logic [POWER_W-1:0] power2_reg;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic               best_done;
    logic [POWER_W-1:0] best_power;

    // Table memory.
    assign wr_data = '{key_vector: req_item.key_vector,
                       key_nop:    req_item.key_nop,
                       power:      req_item.entry_power};

    nnl_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Chain of cells: one squaring cell per coordinate, then the minimum cell.
    nnl_sq_cell u_cell_x (
        .clk (clk),
        .a   (rd_data.key_nop),
        .b   (qx_reg),
        .sq  (sq_x)
    );

    nnl_sq_cell u_cell_y (
        .clk (clk),
        .a   (rd_data.key_vector),
        .b   (qy_reg),
        .sq  (sq_y)
    );

    nnl_best u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag2_reg),
        .sq_x       (sq_x),
        .sq_y       (sq_y),
        .power      (power2_reg),
        .done       (best_done),
        .best_power (best_power)
    );

    // Sequencer: next state, table control and result staging.
    always_comb
    begin
        req_stall      = (state_reg != FSM_IDLE);
        accept         = req_valid && !req_stall;
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        scan_inc       = scan_reg + 1'b1;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        issue_tag      = '{valid: 1'b0, first: 1'b0, last: 1'b0};

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    if (req_item.cmd == CMD_LOAD)
                    begin
                        state_next = FSM_PUT;
                        if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            res_next = '{power_out: '0, status: ST_FULL};
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            res_next   = '{power_out: '0, status: ST_LOADED};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = FSM_PUT;
                        res_next   = '{power_out: '0, status: ST_EMPTY};
                    end
                    else
                    begin
                        state_next = FSM_SCAN;
                        scan_next  = '0;
                    end
                end
            end
            FSM_SCAN:
            begin
                rd_en     = 1'b1;
                issue_tag = '{valid: 1'b1,
                              first: (scan_reg == '0),
                              last:  (scan_inc == count_reg)};
                scan_next = scan_inc;
                if (scan_inc == count_reg)
                begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN:
            begin
                if (best_done)
                begin
                    res_next   = '{power_out: best_power, status: ST_FOUND};
                    state_next = FSM_PUT;
                end
            end
            FSM_PUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = res_reg;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
            tag0_reg      <= '{valid: 1'b0, first: 1'b0, last: 1'b0};
            tag1_reg      <= '{valid: 1'b0, first: 1'b0, last: 1'b0};
            tag2_reg      <= '{valid: 1'b0, first: 1'b0, last: 1'b0};
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
            tag0_reg      <= issue_tag;
            tag1_reg      <= tag0_reg;
            tag2_reg      <= tag1_reg;
        end
    end

    // Payload registers: query key, staged result, output and power delay line.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= req_item.key_nop;
            qy_reg <= req_item.key_vector;
        end
        res_reg      <= res_next;
        res_item_reg <= res_item_next;
        power1_reg   <= rd_data.power;
        power2_reg   <= power1_reg;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Checks on the sequencer and the entry count.
    `NNL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(TABLE_DEPTH), "entry count over depth")
    `NNL_ASSERT_IMP(a_done_in_drain, best_done, state_reg == FSM_DRAIN, "scan done outside drain")
    `NNL_ASSERT_IMP(a_scan_in_range, state_reg == FSM_SCAN, scan_reg < count_reg, "scan past count")
    `NNL_ASSERT_NEXT(a_load_count, accept && req_item.cmd == CMD_LOAD && count_reg < CW'(TABLE_DEPTH), count_reg == CW'($past(count_reg) + 1'b1), "load did not add entry")

endmodule

@@ hdl/nnl_store.sv @@
module nnl_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  nnl_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output nnl_pkg::entry_t rd_data
);
    import nnl_pkg::*;

    entry_t mem_reg [DEPTH];
    entry_t rd_data_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/nnl_sq_cell.sv @@
module nnl_sq_cell (
    input  logic                     clk,
    input  logic [nnl_pkg::KEY_W-1:0] a,
    input  logic [nnl_pkg::KEY_W-1:0] b,
    output logic [nnl_pkg::SQ_W-1:0]  sq
);
    import nnl_pkg::*;

    logic [KEY_W-1:0] diff_reg;
    logic [KEY_W-1:0] diff_next;
    logic [SQ_W-1:0]  sq_reg;
    logic [SQ_W-1:0]  sq_next;

    // First step: absolute difference; second step: its square.
    always_comb
    begin
        diff_next = (a > b) ? (a - b) : (b - a);
        sq_next   = {{KEY_W{1'b0}}, diff_reg} * {{KEY_W{1'b0}}, diff_reg};
    end

    // Each cell hands its result to the next stage every cycle.
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg   <= sq_next;
    end

    assign sq = sq_reg;

endmodule

@@ hdl/nnl_best.sv @@
module nnl_best (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nnl_pkg::scan_tag_t          tag,
    input  logic [nnl_pkg::SQ_W-1:0]    sq_x,
    input  logic [nnl_pkg::SQ_W-1:0]    sq_y,
    input  logic [nnl_pkg::POWER_W-1:0] power,
    output logic                        done,
    output logic [nnl_pkg::POWER_W-1:0] best_power
);
    import nnl_pkg::*;

    logic [DIST_W-1:0]  dist_sum;
    logic               take;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [POWER_W-1:0] best_power_reg;
    logic               done_reg;

    // Sum the squared differences; a strictly smaller distance replaces the best,
    // so on a tie the earlier entry is kept.
    always_comb
    begin
        dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
        take     = tag.valid && (tag.first || (dist_sum < best_dist_reg));
    end

    // Running minimum and the power that goes with it.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg  <= dist_sum;
            best_power_reg <= power;
        end
    end

    // Pulse once the last entry of a scan has been compared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag.valid && tag.last;
        end
    end

    assign done       = done_reg;
    assign best_power = best_power_reg;

endmodule
